// ===== hdl/jhash_pkg.sv =====
// Shared types and constants for the streaming 96-bit-mix byte hash.
// No dependencies; imported by the front, queue and back modules.
package jhash_pkg;

   localparam logic [31:0] GOLDEN_INIT   = 32'h9e3779b9;
   localparam logic [3:0]  BLOCK_END_POS = 4'd11;   // position of the 12th byte
   localparam logic [3:0]  MIX_LAST_STEP = 4'd8;    // nine mix lines, one per cycle

   // one unit of work handed from the front to the back
   typedef struct packed {
      logic [31:0] word_a;
      logic [31:0] word_b;
      logic [31:0] word_c;     // full third word, or tail bytes already moved up a byte
      logic [31:0] key_len;
      logic        block_full;
      logic        key_end;
   } job_type;

endpackage

// ===== hdl/jhash_front.sv =====
// Front end: takes key bytes, packs them little-endian into block words
// and posts a job at each full block and at the end of a key. Uses jhash_pkg.
module jhash_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_is_last,
   input  logic                req_no_byte,
   input  logic                q_ready,
   output logic                q_push,
   output jhash_pkg::job_type  q_job
);
   import jhash_pkg::*;

   logic [31:0] word_a_ff, word_a_in;
   logic [31:0] word_b_ff, word_b_in;
   logic [23:0] word_c_ff, word_c_in;
   logic [3:0]  pos_ff, pos_in;
   logic [31:0] len_ff, len_in;

   logic        accept;
   logic        take_byte;
   logic        block_full;
   logic [31:0] placed;
   logic [31:0] wa_new, wb_new;
   logic [23:0] wc_new;
   logic [31:0] len_new;

   assign req_ready  = q_ready;
   assign accept     = req_valid && req_ready;
   assign take_byte  = !req_no_byte;
   assign block_full = take_byte && (pos_ff == BLOCK_END_POS);
   assign placed     = {24'h000000, req_data_byte} << {pos_ff[1:0], 3'b000};
   assign len_new    = len_ff + {31'd0, take_byte};

   always_comb begin
      wa_new = word_a_ff;
      wb_new = word_b_ff;
      wc_new = word_c_ff;
      if (take_byte) begin
         case (pos_ff[3:2])
            2'd0:    wa_new = word_a_ff | placed;
            2'd1:    wb_new = word_b_ff | placed;
            2'd2:    wc_new = word_c_ff | placed[23:0];
            default: wc_new = word_c_ff;
         endcase
      end
   end

   always_comb begin
      q_job.word_a     = wa_new;
      q_job.word_b     = wb_new;
      q_job.word_c     = block_full ? {req_data_byte, word_c_ff} : {wc_new, 8'h00};
      q_job.key_len    = len_new;
      q_job.block_full = block_full;
      q_job.key_end    = req_is_last;
   end

   assign q_push = accept && (block_full || req_is_last);

   always_comb begin
      word_a_in = word_a_ff;
      word_b_in = word_b_ff;
      word_c_in = word_c_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      if (accept) begin
         if (block_full || req_is_last) begin
            word_a_in = '0;
            word_b_in = '0;
            word_c_in = '0;
            pos_in    = '0;
         end else begin
            word_a_in = wa_new;
            word_b_in = wb_new;
            word_c_in = wc_new;
            pos_in    = pos_ff + {3'd0, take_byte};
         end
         len_in = req_is_last ? 32'd0 : len_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_a_ff <= '0;
         word_b_ff <= '0;
         word_c_ff <= '0;
         pos_ff    <= '0;
         len_ff    <= '0;
      end else begin
         word_a_ff <= word_a_in;
         word_b_ff <= word_b_in;
         word_c_ff <= word_c_in;
         pos_ff    <= pos_in;
         len_ff    <= len_in;
      end
   end

endmodule

// ===== hdl/jhash_queue.sv =====
// Short job queue between the front and back ends.
// Depends on jhash_pkg for the job type.
module jhash_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jhash_pkg::job_type  push_job,
   output logic                push_ready,
   input  logic                pop,
   output logic                pop_valid,
   output jhash_pkg::job_type  pop_job
);
   import jhash_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hdl/jhash_back.sv =====
// Back end: adds block words into the accumulators and runs the mix,
// one mix line per cycle; drives the registered result. Uses jhash_pkg.
module jhash_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  jhash_pkg::job_type  q_job,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_hash_value
);
   import jhash_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MIX  = 4'b0010,
      ST_LEN  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [31:0] a_m, b_m, c_m;
   logic [3:0]  step_ff, step_in;
   logic        full_ff, full_in;
   logic        end_ff, end_in;
   logic        len_added_ff, len_added_in;
   logic [31:0] len_ff, len_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_hash_ff, rsp_hash_in;
   logic        out_free;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;
   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign q_pop          = (state_ff == ST_IDLE) && q_valid;

   // one line of the 96-bit mix
   always_comb begin
      a_m = a_ff;
      b_m = b_ff;
      c_m = c_ff;
      case (step_ff)
         4'd0:    a_m = (a_ff - b_ff - c_ff) ^ (c_ff >> 13);
         4'd1:    b_m = (b_ff - c_ff - a_ff) ^ (a_ff << 8);
         4'd2:    c_m = (c_ff - a_ff - b_ff) ^ (b_ff >> 13);
         4'd3:    a_m = (a_ff - b_ff - c_ff) ^ (c_ff >> 12);
         4'd4:    b_m = (b_ff - c_ff - a_ff) ^ (a_ff << 16);
         4'd5:    c_m = (c_ff - a_ff - b_ff) ^ (b_ff >> 5);
         4'd6:    a_m = (a_ff - b_ff - c_ff) ^ (c_ff >> 3);
         4'd7:    b_m = (b_ff - c_ff - a_ff) ^ (a_ff << 10);
         4'd8:    c_m = (c_ff - a_ff - b_ff) ^ (b_ff >> 15);
         default: c_m = c_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      step_in      = step_ff;
      full_in      = full_ff;
      end_in       = end_ff;
      len_added_in = len_added_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hash_in  = rsp_hash_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               // a key ending mid-block takes its length in with the tail bytes
               a_in         = a_ff + q_job.word_a;
               b_in         = b_ff + q_job.word_b;
               c_in         = c_ff + q_job.word_c
                              + (q_job.block_full ? 32'd0 : q_job.key_len);
               full_in      = q_job.block_full;
               end_in       = q_job.key_end;
               len_in       = q_job.key_len;
               len_added_in = 1'b0;
               step_in      = '0;
               state_in     = ST_MIX;
            end
         end
         ST_MIX: begin
            a_in = a_m;
            b_in = b_m;
            c_in = c_m;
            if (step_ff == MIX_LAST_STEP) begin
               step_in = '0;
               if (end_ff && full_ff && !len_added_ff) begin
                  state_in = ST_LEN;
               end else if (end_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_LEN: begin
            // key ended on a block boundary: length alone, then the closing mix
            c_in         = c_ff + len_ff;
            len_added_in = 1'b1;
            state_in     = ST_MIX;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = c_ff;
               a_in         = GOLDEN_INIT;
               b_in         = GOLDEN_INIT;
               c_in         = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         a_ff         <= GOLDEN_INIT;
         b_ff         <= GOLDEN_INIT;
         c_ff         <= '0;
         step_ff      <= '0;
         full_ff      <= 1'b0;
         end_ff       <= 1'b0;
         len_added_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         c_ff         <= c_in;
         step_ff      <= step_in;
         full_ff      <= full_in;
         end_ff       <= end_in;
         len_added_ff <= len_added_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      rsp_hash_ff <= rsp_hash_in;
   end

endmodule

// ===== hdl/jenkins96_byte_hash.sv =====
// Result: hash valid once the last request of a key has been mixed, with an extra
// mix when that request completes a 12-byte block (extra block mix), plus any queued work.
// Throughput: one byte per cycle while the queue has room; each full block and
// each key end runs the back end through the nine-line mix, done one line per cycle.
// Reset: synchronous, active high; empties the queue, restores the accumulators
// and drops any pending result.
module jenkins96_byte_hash #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_is_last,
   input  logic        req_no_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_hash_value
);
   import jhash_pkg::*;

   logic    q_ready, q_push, q_valid, q_pop;
   job_type q_in_job, q_out_job;

   jhash_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_is_last   (req_is_last),
      .req_no_byte   (req_no_byte),
      .q_ready       (q_ready),
      .q_push        (q_push),
      .q_job         (q_in_job)
   );

   jhash_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_in_job),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_job    (q_out_job)
   );

   jhash_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_job          (q_out_job),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

// ===== hdl/jhash_checker.sv =====
// Port-level checks for jenkins96_byte_hash, bound onto the top level.
// No package dependency.
module jhash_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_data_byte,
   input logic        req_is_last,
   input logic        req_no_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_hash_value
);

   // a waiting request holds its payload until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=>
         req_valid && $stable({req_data_byte, req_is_last, req_no_byte}))
      else $error("request dropped or changed while waiting");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_value))
      else $error("result dropped or changed while stalled");

   // no result survives reset
   a_rsp_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // queue is empty after reset, so requests are taken at once
   a_ready_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> req_ready)
      else $error("request port not ready after reset");

endmodule

bind jenkins96_byte_hash jhash_checker u_jhash_checker (.*);
